// ----- rtl/rhsv_pkg.sv -----
// Shared types and constants for the RGB to HSV pixel converter.
// No dependencies; imported by every module in rtl/.
package rhsv_pkg;

  localparam int ChanW            = 8;                          // colour channel width
  localparam int FracW            = 16;                         // hue and saturation fraction width
  localparam int HueDivW          = 11;                         // 6 * chroma, max 1530
  localparam int SatDivW          = ChanW;                      // divisor is the maximum channel
  localparam int AbsNumW          = 12;                         // |hue numerator| before range check
  localparam int SignedW          = 13;                         // signed hue numerator
  localparam int DivStepsPerStage = 4;                          // quotient bits per divider stage
  localparam int NumDivStages     = FracW / DivStepsPerStage;
  localparam int InDataW          = 3 * ChanW;
  localparam int OutDataW         = 2 * FracW + ChanW;

  // Work carried down the divider pipeline
  typedef struct packed {
    logic [HueDivW-1:0] hue_rem;
    logic [HueDivW-1:0] hue_div;
    logic [FracW-1:0]   hue_q;
    logic               hue_zero;   // grey pixel
    logic               hue_full;   // quotient reaches a full turn
    logic [SatDivW-1:0] sat_rem;
    logic [SatDivW-1:0] sat_div;
    logic [FracW-1:0]   sat_q;
    logic               sat_zero;   // black pixel
    logic               sat_full;   // chroma equals maximum
    logic [ChanW-1:0]   val;
  } rhsv_work_t;

endpackage

// ----- rtl/rgb_to_hsv_pixel.sv -----
// Top level of the RGB to HSV pixel converter.
// Depends on rhsv_pkg, rhsv_front and rhsv_div_stage.
//
// Usage:
//   Slave stream carries one RGB pixel per request; master stream carries
//   hue, saturation and value for that pixel, in the same order.
//   Hue and saturation are 16-bit fractions of 1.0, truncated; saturation
//   at 1.0 reads 65535. Grey pixels give hue 0, black pixels sat 0 too.
//   The pipeline is one stage for channel sort and chroma, then four
//   divider stages each producing 4 quotient bits of both divisions
//   (16 bits in all). Each stage holds one pixel; throughput is one
//   pixel per clock while the receiver is ready.
//   Reset clears all stage valid bits; the block is ready straight after.
//   When the receiver stalls, the pixels already in flight close up any
//   empty stages, so requests are still taken until every stage is full;
//   nothing is dropped or repeated.
module rgb_to_hsv_pixel import rhsv_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // red_in, green_in, blue_in
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata    // hue_out, sat_out, val_out
);

  logic       stage_valid [NumDivStages+1];
  logic       stage_ready [NumDivStages+1];
  rhsv_work_t stage_work  [NumDivStages+1];
  rhsv_work_t last;
  logic [FracW-1:0] hue;
  logic [FracW-1:0] sat;

  rhsv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_red    (s_axis_tdata[ChanW-1:0]),
    .in_green  (s_axis_tdata[2*ChanW-1:ChanW]),
    .in_blue   (s_axis_tdata[3*ChanW-1:2*ChanW]),
    .out_valid (stage_valid[0]),
    .out_ready (stage_ready[0]),
    .out_work  (stage_work[0])
  );

  for (genvar s = 0; s < NumDivStages; s++) begin : g_div
    rhsv_div_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[s]),
      .in_ready  (stage_ready[s]),
      .in_work   (stage_work[s]),
      .out_valid (stage_valid[s+1]),
      .out_ready (stage_ready[s+1]),
      .out_work  (stage_work[s+1])
    );
  end

  assign stage_ready[NumDivStages] = m_axis_tready;
  assign m_axis_tvalid             = stage_valid[NumDivStages];
  assign last                      = stage_work[NumDivStages];

  always_comb begin
    if (last.hue_zero) begin
      hue = '0;
    end else if (last.hue_full) begin
      hue = '1;
    end else begin
      hue = last.hue_q;
    end

    if (last.sat_zero) begin
      sat = '0;
    end else if (last.sat_full) begin
      sat = '1;
    end else begin
      sat = last.sat_q;
    end
  end

  assign m_axis_tdata = {last.val, sat, hue};

endmodule

// ----- rtl/rhsv_front.sv -----
// First pipeline stage: sorts the channels, forms chroma, hue numerator and divisors.
// Depends on rhsv_pkg.
module rhsv_front import rhsv_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ChanW-1:0] in_red,
  input  logic [ChanW-1:0] in_green,
  input  logic [ChanW-1:0] in_blue,
  output logic             out_valid,
  input  logic             out_ready,
  output rhsv_work_t       out_work
);

  logic               swap_gb;
  logic               swap_rg;
  logic [ChanW-1:0]   g1;
  logic [ChanW-1:0]   b1;
  logic [ChanW-1:0]   r2;
  logic [ChanW-1:0]   g2;
  logic [ChanW-1:0]   mn;
  logic [ChanW-1:0]   chroma;
  logic [HueDivW-1:0] chroma6;
  logic [SignedW-1:0] offset;
  logic [SignedW-1:0] num;
  logic [AbsNumW-1:0] abs_num;
  rhsv_work_t         work_next;

  always_comb begin
    swap_gb = in_green < in_blue;
    g1      = swap_gb ? in_blue  : in_green;
    b1      = swap_gb ? in_green : in_blue;
    swap_rg = in_red < g1;
    r2      = swap_rg ? g1     : in_red;
    g2      = swap_rg ? in_red : g1;
    mn      = (g2 < b1) ? g2 : b1;
    chroma  = r2 - mn;
    chroma6 = {1'b0, chroma, 2'b00} + {2'b00, chroma, 1'b0};

    // hue offset in sixths of a turn: 0, -6c, -2c or +4c
    if (swap_rg) begin
      offset = swap_gb ? {3'b000, chroma, 2'b00} : -{4'b0000, chroma, 1'b0};
    end else begin
      offset = swap_gb ? -{2'b00, chroma6} : '0;
    end
    num     = offset + {5'b00000, g2} - {5'b00000, b1};
    abs_num = num[SignedW-1] ? AbsNumW'(-num) : num[AbsNumW-1:0];

    work_next.hue_rem  = abs_num[HueDivW-1:0];
    work_next.hue_div  = chroma6;
    work_next.hue_q    = '0;
    work_next.hue_zero = (chroma == '0);
    work_next.hue_full = (abs_num >= {1'b0, chroma6});
    work_next.sat_rem  = chroma;
    work_next.sat_div  = r2;
    work_next.sat_q    = '0;
    work_next.sat_zero = (r2 == '0);
    work_next.sat_full = (chroma == r2);
    work_next.val      = r2;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_work <= work_next;
    end
  end

endmodule

// ----- rtl/rhsv_div_stage.sv -----
// One stage of the restoring divider: four quotient bits of hue and saturation each.
// Depends on rhsv_pkg.
module rhsv_div_stage import rhsv_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  rhsv_work_t in_work,
  output logic       out_valid,
  input  logic       out_ready,
  output rhsv_work_t out_work
);

  rhsv_work_t       work_next;
  logic [HueDivW:0] hue_rem2;
  logic [SatDivW:0] sat_rem2;

  // remainder stays below the divisor, so doubling needs one extra bit
  always_comb begin
    work_next = in_work;
    hue_rem2  = '0;
    sat_rem2  = '0;
    for (int i = 0; i < DivStepsPerStage; i++) begin
      hue_rem2 = {work_next.hue_rem, 1'b0};
      if (hue_rem2 >= {1'b0, work_next.hue_div}) begin
        hue_rem2          = hue_rem2 - {1'b0, work_next.hue_div};
        work_next.hue_q   = {work_next.hue_q[FracW-2:0], 1'b1};
      end else begin
        work_next.hue_q   = {work_next.hue_q[FracW-2:0], 1'b0};
      end
      work_next.hue_rem = hue_rem2[HueDivW-1:0];

      sat_rem2 = {work_next.sat_rem, 1'b0};
      if (sat_rem2 >= {1'b0, work_next.sat_div}) begin
        sat_rem2          = sat_rem2 - {1'b0, work_next.sat_div};
        work_next.sat_q   = {work_next.sat_q[FracW-2:0], 1'b1};
      end else begin
        work_next.sat_q   = {work_next.sat_q[FracW-2:0], 1'b0};
      end
      work_next.sat_rem = sat_rem2[SatDivW-1:0];
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_work <= work_next;
    end
  end

endmodule

// ----- rtl/rhsv_checker.sv -----
// Port-level assertions for rgb_to_hsv_pixel, bound to the top level.
// Depends on rhsv_pkg.
module rhsv_checker import rhsv_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [InDataW-1:0]  s_axis_tdata,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid straight after reset");

  // an open receiver means every stage can move
  a_ready_path: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("input blocked while receiver ready");

  // unstalled request is delivered; a black pixel gives all zeros
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && m_axis_tready) ##1 m_axis_tready
      ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
    |=> m_axis_tvalid && ($past(s_axis_tdata, 5) != '0 || m_axis_tdata == '0))
    else $error("request not delivered after pipeline latency");

endmodule

bind rgb_to_hsv_pixel rhsv_checker u_checker (.*);
